/* sv/assert_macros.svh */
// Assertion macros used by the checker file lhl_checker.sv.
// Depends on nothing; each macro expands to one labelled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, clocked on clk, off during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* sv/lhl_pkg.sv */
// Types and constants for the lock requester with deadline.
// Used by every module of the block; depends on nothing.
package lhl_pkg;

    typedef enum logic [2:0] {
        LC_IDLE     = 3'd0,
        LC_WAITING  = 3'd1,
        LC_HOLDING  = 3'd2,
        LC_FINISHED = 3'd3,
        LC_INVALID  = 3'd4
    } lhl_state_t;

    typedef enum logic [2:0] {
        STAT_IDLE     = 3'd0,
        STAT_INVALID  = 3'd1,
        STAT_WAITING  = 3'd2,
        STAT_ACQUIRED = 3'd3,
        STAT_HOLDING  = 3'd4,
        STAT_EXPIRED  = 3'd5,
        STAT_RELEASED = 3'd6
    } lhl_status_t;

    localparam logic REQ_BEGIN = 1'b0;
    localparam logic REQ_STEP  = 1'b1;

    localparam logic [31:0] WINDOW_MAX = 32'h7FFF_FFFF;

    typedef struct packed {
        logic        req_type;
        logic [31:0] now_ms;
        logic [31:0] window_ms;
        logic        continue_holding;
        logic        lock_granted;
    } lhl_item_t;

    typedef struct packed {
        logic        begin_accepted;
        lhl_status_t step_status;
        logic        lock_attempt;
        logic        release_pulse;
    } lhl_result_t;

    typedef struct packed {
        lhl_state_t  state;
        logic [31:0] deadline_ms;
        logic        owns_lock;
    } lhl_ctx_t;

endpackage

/* sv/lock_hold_lifecycle_with_deadline_core.sv */
// Lock requester with acquisition deadline, top level.
// Path from input beat to result beat: input register, then result register.
// Throughput: one item per cycle while out_stall is low; the lifecycle update is one pass of lhl_step.
// Output stall backs up through the input register to in_stall.
// Reset (rst_n, async low): state idle, deadline 0, lock not owned, hooks_present 1.
module lock_hold_lifecycle_with_deadline_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        req_type,
    input  logic [31:0] now_ms,
    input  logic [31:0] window_ms,
    input  logic        continue_holding,
    input  logic        lock_granted,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        begin_accepted,
    output logic [2:0]  step_status,
    output logic        lock_attempt,
    output logic        release_pulse
);
    import lhl_pkg::*;

    lhl_item_t   in_item;
    lhl_item_t   item;
    logic        item_valid;
    logic        advance;
    lhl_ctx_t    ctx_reg;
    lhl_ctx_t    ctx_next;
    lhl_result_t result;
    lhl_result_t result_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        hooks_reg;

    assign in_item.req_type         = req_type;
    assign in_item.now_ms           = now_ms;
    assign in_item.window_ms        = window_ms;
    assign in_item.continue_holding = continue_holding;
    assign in_item.lock_granted     = lock_granted;

    lhl_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .take       (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    lhl_step u_step (
        .item          (item),
        .ctx           (ctx_reg),
        .hooks_present (hooks_reg),
        .ctx_next      (ctx_next),
        .result        (result)
    );

    // advance when the result slot is free or draining this cycle
    assign advance        = item_valid && (!out_valid_reg || !out_stall);
    assign out_valid_next = advance || (out_valid_reg && out_stall);
    assign cfg_ready      = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctx_reg.state       <= LC_IDLE;
            ctx_reg.deadline_ms <= 32'd0;
            ctx_reg.owns_lock   <= 1'b0;
            out_valid_reg       <= 1'b0;
            hooks_reg           <= 1'b1;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                ctx_reg <= ctx_next;
            end
            if (cfg_valid && cfg_ready)
            begin
                hooks_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result;
        end
    end

    assign out_valid      = out_valid_reg;
    assign begin_accepted = result_reg.begin_accepted;
    assign step_status    = result_reg.step_status;
    assign lock_attempt   = result_reg.lock_attempt;
    assign release_pulse  = result_reg.release_pulse;

endmodule

/* sv/lhl_in_stage.sv */
// Input register of the lock requester: captures one item beat and holds it
// until the step logic consumes it. Depends on lhl_pkg.
module lhl_in_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  lhl_pkg::lhl_item_t in_item,
    input  logic               take,
    output logic               item_valid,
    output lhl_pkg::lhl_item_t item
);
    import lhl_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    lhl_item_t item_reg;
    logic      load;

    assign in_stall   = valid_reg && !take;
    assign load       = in_valid && !in_stall;
    assign valid_next = load || (valid_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

/* sv/lhl_step.sv */
// Combinational lifecycle update for one item: next context and result.
// Depends on lhl_pkg.
module lhl_step (
    input  lhl_pkg::lhl_item_t   item,
    input  lhl_pkg::lhl_ctx_t    ctx,
    input  logic                 hooks_present,
    output lhl_pkg::lhl_ctx_t    ctx_next,
    output lhl_pkg::lhl_result_t result
);
    import lhl_pkg::*;

    logic [31:0] sum_ms;
    logic [31:0] diff_ms;
    logic        deadline_passed;
    logic        may_begin;
    logic        bad_begin;

    assign sum_ms          = item.now_ms + item.window_ms;
    assign diff_ms         = item.now_ms - ctx.deadline_ms;
    // wrap-safe compare: reached once the difference is non-negative
    assign deadline_passed = !diff_ms[31];
    assign may_begin       = !ctx.owns_lock && (ctx.state == LC_IDLE ||
                             ctx.state == LC_FINISHED || ctx.state == LC_INVALID);
    assign bad_begin       = !hooks_present || (item.window_ms == 32'd0) ||
                             (item.window_ms > WINDOW_MAX);

    always_comb
    begin
        ctx_next              = ctx;
        result.begin_accepted = 1'b0;
        result.step_status    = STAT_IDLE;
        result.lock_attempt   = 1'b0;
        result.release_pulse  = 1'b0;

        if (item.req_type == REQ_BEGIN)
        begin
            if (may_begin)
            begin
                if (bad_begin)
                begin
                    ctx_next.state = LC_INVALID;
                end
                else
                begin
                    ctx_next.deadline_ms  = sum_ms;
                    ctx_next.state        = LC_WAITING;
                    result.begin_accepted = 1'b1;
                end
            end
        end
        else if (!hooks_present)
        begin
            // hooks gone: force invalid, keep ownership as it is
            ctx_next.state     = LC_INVALID;
            result.step_status = STAT_INVALID;
        end
        else
        begin
            unique case (ctx.state)
                LC_IDLE, LC_FINISHED:
                begin
                    result.step_status = STAT_IDLE;
                end
                LC_INVALID:
                begin
                    result.step_status = STAT_INVALID;
                end
                LC_WAITING:
                begin
                    if (!item.continue_holding || deadline_passed)
                    begin
                        ctx_next.state     = LC_FINISHED;
                        result.step_status = STAT_EXPIRED;
                    end
                    else
                    begin
                        result.lock_attempt = 1'b1;
                        if (item.lock_granted)
                        begin
                            ctx_next.owns_lock = 1'b1;
                            ctx_next.state     = LC_HOLDING;
                            result.step_status = STAT_ACQUIRED;
                        end
                        else
                        begin
                            result.step_status = STAT_WAITING;
                        end
                    end
                end
                LC_HOLDING:
                begin
                    if (!item.continue_holding)
                    begin
                        result.release_pulse = ctx.owns_lock;
                        ctx_next.owns_lock   = 1'b0;
                        ctx_next.state       = LC_FINISHED;
                        result.step_status   = STAT_RELEASED;
                    end
                    else
                    begin
                        result.step_status = STAT_HOLDING;
                    end
                end
                default:
                begin
                    result.step_status = STAT_IDLE;
                end
            endcase
        end
    end

endmodule

/* sv/lhl_checker.sv */
// Port-level checks for the lock requester, bound to the top level.
// Depends on lhl_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lhl_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic        begin_accepted,
    input logic [2:0]  step_status,
    input logic        lock_attempt,
    input logic        release_pulse
);
    import lhl_pkg::*;

    // a stalled result beat stays offered
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)

    // an accepted begin carries no step outcome
    `ASSERT_IMP(a_begin_clean, clk, rst_n, out_valid && begin_accepted,
        step_status == STAT_IDLE && !lock_attempt && !release_pulse)

    // a release only comes with the released status
    `ASSERT_IMP(a_release_status, clk, rst_n, out_valid && release_pulse,
        step_status == STAT_RELEASED && !lock_attempt)

    // a try-acquire ends either acquired or still waiting
    `ASSERT_IMP(a_attempt_status, clk, rst_n, out_valid && lock_attempt,
        step_status == STAT_ACQUIRED || step_status == STAT_WAITING)

endmodule

bind lock_hold_lifecycle_with_deadline_core lhl_checker u_lhl_checker (.*);

/* sim/tb_top.sv */
// Testbench for lock_hold_lifecycle_with_deadline_core: directed lifecycles and random traffic.
// Keeps its own lifecycle predictor and checks every result beat; depends on lhl_pkg and the core.
module tb_top;
    import lhl_pkg::*;

    localparam int CYCLE_LIMIT  = 250000;
    localparam int DRAIN_CYCLES = 6;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic        req_type;
    logic [31:0] now_ms;
    logic [31:0] window_ms;
    logic        continue_holding;
    logic        lock_granted;
    logic        out_valid;
    logic        out_stall;
    logic        begin_accepted;
    logic [2:0]  step_status;
    logic        lock_attempt;
    logic        release_pulse;

    // predictor copy of the block state and its register
    lhl_state_t  lc_state;
    logic [31:0] lc_deadline;
    logic        lc_owns;
    logic        hooks_en;

    lhl_result_t pending_results[$];
    lhl_result_t want;
    logic [31:0] clock_ms;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_left;
    int          fail_count;
    int          cycle_count;

    lock_hold_lifecycle_with_deadline_core u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .req_type         (req_type),
        .now_ms           (now_ms),
        .window_ms        (window_ms),
        .continue_holding (continue_holding),
        .lock_granted     (lock_granted),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .begin_accepted   (begin_accepted),
        .step_status      (step_status),
        .lock_attempt     (lock_attempt),
        .release_pulse    (release_pulse)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     pending_results.size());
            $display("tb_top failed");
            $finish;
        end
    end

    // Receiver: hold off for a counted stretch when asked, else stall at random
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall = 1'b1;
            hold_left = hold_left - 1;
        end
        else
            out_stall = ($urandom_range(99) < recv_stall_pct);
    end

    function automatic lhl_result_t predict_lock_result(input lhl_item_t it);
        lhl_result_t r;
        logic [31:0] since;
        r = '0;
        r.step_status = STAT_IDLE;
        since = it.now_ms - lc_deadline;
        if (it.req_type == REQ_BEGIN)
        begin
            if (!lc_owns && (lc_state == LC_IDLE || lc_state == LC_FINISHED ||
                             lc_state == LC_INVALID))
            begin
                if (!hooks_en || it.window_ms == 32'd0 || it.window_ms > WINDOW_MAX)
                    lc_state = LC_INVALID;
                else
                begin
                    lc_deadline = it.now_ms + it.window_ms;
                    lc_state = LC_WAITING;
                    r.begin_accepted = 1'b1;
                end
            end
        end
        else if (!hooks_en)
        begin
            lc_state = LC_INVALID;
            r.step_status = STAT_INVALID;
        end
        else if (lc_state == LC_INVALID)
            r.step_status = STAT_INVALID;
        else if (lc_state == LC_WAITING)
        begin
            // deadline reached once the wrapped difference is non-negative
            if (!it.continue_holding || !since[31])
            begin
                lc_state = LC_FINISHED;
                r.step_status = STAT_EXPIRED;
            end
            else
            begin
                r.lock_attempt = 1'b1;
                if (it.lock_granted)
                begin
                    lc_owns = 1'b1;
                    lc_state = LC_HOLDING;
                    r.step_status = STAT_ACQUIRED;
                end
                else
                    r.step_status = STAT_WAITING;
            end
        end
        else if (lc_state == LC_HOLDING)
        begin
            if (!it.continue_holding)
            begin
                r.release_pulse = lc_owns;
                lc_owns = 1'b0;
                lc_state = LC_FINISHED;
                r.step_status = STAT_RELEASED;
            end
            else
                r.step_status = STAT_HOLDING;
        end
        return r;
    endfunction

    // Compare each result beat with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result with none expected: acc=%0b st=%0d att=%0b rel=%0b",
                         $time, begin_accepted, step_status, lock_attempt, release_pulse);
                fail_count = fail_count + 1;
            end
            else
            begin
                want = pending_results.pop_front();
                if (begin_accepted !== want.begin_accepted)
                begin
                    $display("%0t: begin_accepted expected %0b got %0b", $time,
                             want.begin_accepted, begin_accepted);
                    fail_count = fail_count + 1;
                end
                if (step_status !== want.step_status)
                begin
                    $display("%0t: step_status expected %0d got %0d", $time,
                             want.step_status, step_status);
                    fail_count = fail_count + 1;
                end
                if (lock_attempt !== want.lock_attempt)
                begin
                    $display("%0t: lock_attempt expected %0b got %0b", $time,
                             want.lock_attempt, lock_attempt);
                    fail_count = fail_count + 1;
                end
                if (release_pulse !== want.release_pulse)
                begin
                    $display("%0t: release_pulse expected %0b got %0b", $time,
                             want.release_pulse, release_pulse);
                    fail_count = fail_count + 1;
                end
            end
        end
    end

    // Called and returns at a falling edge
    task automatic send_item(input lhl_item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid         = 1'b1;
        req_type         = it.req_type;
        now_ms           = it.now_ms;
        window_ms        = it.window_ms;
        continue_holding = it.continue_holding;
        lock_granted     = it.lock_granted;
        do
            @(posedge clk);
        while (in_stall);
        pending_results.push_back(predict_lock_result(it));
        @(negedge clk);
    endtask

    task automatic wait_idle();
        in_valid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_hooks(input logic v);
        wait_idle();
        cfg_valid = 1'b1;
        cfg_data  = v;
        do
            @(posedge clk);
        while (!cfg_ready);
        hooks_en = v;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    function automatic lhl_item_t mk(input logic rq, input logic [31:0] t,
                                     input logic [31:0] w, input logic c, input logic g);
        lhl_item_t it;
        it.req_type         = rq;
        it.now_ms           = t;
        it.window_ms        = w;
        it.continue_holding = c;
        it.lock_granted     = g;
        return it;
    endfunction

    function automatic logic [31:0] pick_window();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 70)
            return $urandom_range(24, 1);
        else if (roll < 85)
            return $urandom_range(WINDOW_MAX, 1);
        else if (roll < 90)
            return ($urandom_range(1) != 0) ? WINDOW_MAX : 32'd1;
        else if (roll < 95)
            return 32'd0;
        return 32'h8000_0000 | $urandom();
    endfunction

    // Mostly well-formed lifecycles driven by the predicted state, some noise
    function automatic lhl_item_t pick_item();
        lhl_item_t it;
        int unsigned roll;
        case ($urandom_range(19))
            0: clock_ms = clock_ms + $urandom();
            1: clock_ms = 32'hFFFF_FFF0 + $urandom_range(15);
            default: clock_ms = clock_ms + $urandom_range(3);
        endcase
        it = mk(REQ_STEP, clock_ms, $urandom(), 1'($urandom_range(1)),
                1'($urandom_range(1)));
        roll = $urandom_range(99);
        if (roll < 8)
        begin
            it.req_type = 1'($urandom_range(1));
            it.now_ms   = $urandom();
        end
        else if (lc_state == LC_WAITING)
        begin
            if (roll < 13)
                it.req_type = REQ_BEGIN;
            it.continue_holding = ($urandom_range(99) < 93);
            it.lock_granted     = ($urandom_range(99) < 20);
        end
        else if (lc_state == LC_HOLDING)
        begin
            if (roll < 13)
                it.req_type = REQ_BEGIN;
            it.continue_holding = ($urandom_range(99) < 80);
        end
        else if (roll < 85)
        begin
            it.req_type  = REQ_BEGIN;
            it.window_ms = pick_window();
        end
        return it;
    endfunction

    task automatic run_random(input int n, input int idle_pct, input int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (n) send_item(pick_item());
        wait_idle();
    endtask

    task automatic test_directed_lifecycle();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_item(mk(REQ_STEP,  32'h0000_0000, 32'h0,         1'b1, 1'b1));
        send_item(mk(REQ_BEGIN, 32'h0000_0010, 32'h0,         1'b0, 1'b0));
        send_item(mk(REQ_STEP,  32'h0000_0011, 32'hFFFF_FFFF, 1'b1, 1'b1));
        send_item(mk(REQ_BEGIN, 32'h0000_0012, 32'h8000_0000, 1'b1, 1'b1));
        send_item(mk(REQ_BEGIN, 32'h0000_0013, 32'hFFFF_FFFF, 1'b0, 1'b1));
        // widest window from the top of time: deadline wraps
        send_item(mk(REQ_BEGIN, 32'hFFFF_FFFF, WINDOW_MAX,    1'b1, 1'b0));
        send_item(mk(REQ_STEP,  32'hFFFF_FFFF, 32'h0,         1'b1, 1'b0));
        send_item(mk(REQ_BEGIN, 32'h0000_0000, 32'd5,         1'b0, 1'b0));
        send_item(mk(REQ_STEP,  32'h7FFF_FFFD, 32'h0,         1'b1, 1'b1));
        send_item(mk(REQ_STEP,  32'h7FFF_FFFF, 32'h0,         1'b1, 1'b0));
        send_item(mk(REQ_BEGIN, 32'h0000_0000, 32'd1,         1'b1, 1'b1));
        send_item(mk(REQ_STEP,  32'h8000_0000, 32'h0,         1'b0, 1'b1));
        send_item(mk(REQ_STEP,  32'h0000_0000, 32'h0,         1'b0, 1'b0));
        // expire exactly at the deadline
        send_item(mk(REQ_BEGIN, 32'h0000_1000, 32'd1,         1'b0, 1'b0));
        send_item(mk(REQ_STEP,  32'h0000_1000, 32'h0,         1'b1, 1'b0));
        send_item(mk(REQ_STEP,  32'h0000_1001, 32'h0,         1'b1, 1'b1));
        send_item(mk(REQ_BEGIN, 32'h0000_2000, 32'd100,       1'b1, 1'b1));
        send_item(mk(REQ_STEP,  32'h0000_2000, 32'h0,         1'b0, 1'b1));
        wait_idle();
    endtask

    task automatic test_hooks_absent();
        write_hooks(1'b0);
        send_item(mk(REQ_BEGIN, 32'h0000_3000, 32'd10, 1'b1, 1'b1));
        send_item(mk(REQ_STEP,  32'h0000_3001, 32'h0,  1'b1, 1'b1));
        write_hooks(1'b1);
        send_item(mk(REQ_BEGIN, 32'h0000_3002, 32'd10, 1'b0, 1'b0));
        send_item(mk(REQ_STEP,  32'h0000_3003, 32'h0,  1'b1, 1'b0));
        wait_idle();
    endtask

    task automatic test_random_hooks_absent();
        // drop any owned lock first, or begins stay refused for good
        send_item(mk(REQ_STEP, clock_ms, 32'h0, 1'b0, 1'b0));
        write_hooks(1'b0);
        run_random(50, 30, 30);
        write_hooks(1'b1);
    endtask

    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        @(posedge clk);
        hold_left = 150;
        @(negedge clk);
        repeat (50) send_item(pick_item());
        wait_idle();
    endtask

    task automatic test_hooks_lost_while_owning();
        send_item(mk(REQ_STEP,  clock_ms,      32'h0,  1'b0, 1'b0));
        send_item(mk(REQ_BEGIN, 32'h0000_0100, 32'd50, 1'b1, 1'b0));
        send_item(mk(REQ_STEP,  32'h0000_0101, 32'h0,  1'b1, 1'b1));
        write_hooks(1'b0);
        send_item(mk(REQ_STEP,  32'h0000_0102, 32'h0,  1'b1, 1'b1));
        write_hooks(1'b1);
        send_item(mk(REQ_BEGIN, 32'h0000_0103, 32'd50, 1'b1, 1'b1));
        send_item(mk(REQ_STEP,  32'h0000_0104, 32'h0,  1'b0, 1'b0));
        wait_idle();
    endtask

    initial
    begin
        rst_n            = 1'b0;
        cfg_valid        = 1'b0;
        cfg_data         = 1'b0;
        in_valid         = 1'b0;
        req_type         = REQ_BEGIN;
        now_ms           = 32'h0;
        window_ms        = 32'h0;
        continue_holding = 1'b0;
        lock_granted     = 1'b0;
        out_stall        = 1'b0;
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        hold_left        = 0;
        fail_count       = 0;
        cycle_count      = 0;
        lc_state         = LC_IDLE;
        lc_deadline      = 32'h0;
        lc_owns          = 1'b0;
        hooks_en         = 1'b1;
        clock_ms         = $urandom();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (DRAIN_CYCLES) @(negedge clk);

        test_directed_lifecycle();
        test_hooks_absent();
        run_random(300, 0, 0);
        run_random(250, 62, 0);
        run_random(250, 0, 62);
        run_random(250, 9, 9);
        test_random_hooks_absent();
        test_backpressure();
        test_hooks_lost_while_owning();

        if (fail_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end
endmodule
